// ===== rtl/core/bsff_pkg.sv =====
package bsff_pkg;

  localparam int unsigned BitIdxW   = 11;
  localparam int unsigned FillCntW  = 9;
  localparam int unsigned LenOutW   = 9;
  localparam int unsigned MemAddrW  = 16;  // covers the largest supported store

  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_ASSIGN = 3'd1,
    CMD_TOGGLE = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_EXTEND = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_OVERFLOW  = 2'd2
  } stat_e;

  typedef struct packed {
    logic [2:0]          command;
    logic [BitIdxW-1:0]  bit_index;
    logic                bit_value;
    logic [7:0]          start_byte;
    logic [7:0]          fill_byte;
    logic [FillCntW-1:0] fill_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               read_bit;
    logic [BitIdxW-1:0] found_bit_index;
    logic [LenOutW-1:0] length_now;
  } out_item_t;

  // one write port and one read port per cycle
  typedef struct packed {
    logic                we;
    logic [MemAddrW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [MemAddrW-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/core/bsff_bit_find.sv =====
module bsff_bit_find (
  input  logic [7:0] byte_i,
  input  logic       want_i,
  output logic       hit_o,
  output logic [2:0] idx_o
);

  logic [7:0] cand;

  // lowest bit equal to want_i
  always_comb begin
    cand  = want_i ? byte_i : ~byte_i;
    hit_o = |cand;
    idx_o = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (cand[k]) begin
        idx_o = 3'(k);
      end
    end
  end

endmodule

// ===== rtl/core/bsff_seq.sv =====
module bsff_seq #(
  parameter int unsigned STORE_BYTES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  bsff_pkg::in_item_t   item_i,
  output logic                 done_o,
  output bsff_pkg::out_item_t  result_o,
  output bsff_pkg::mem_req_t   mem_req_o,
  input  logic [7:0]           mem_rdata_i
);
  import bsff_pkg::*;

  localparam int unsigned LW = $clog2(STORE_BYTES + 1);
  localparam int unsigned SW = ((LW > FillCntW) ? LW : FillCntW) + 1;
  localparam logic [SW-1:0] StoreSize = SW'(STORE_BYTES);
  localparam logic [LW-1:0] LastByte  = LW'(STORE_BYTES - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RMW   = 5'b00100,
    S_SCAN  = 5'b01000,
    S_FILL  = 5'b10000
  } state_e;

  state_e    state_q, state_d;
  in_item_t  item_q, item_d;
  logic [LW-1:0] ptr_q, ptr_d;
  logic [LW-1:0] end_q, end_d;
  logic [LW-1:0] len_q, len_d;
  logic      done_q, done_d;
  out_item_t res_q, res_d;

  logic [7:0]    byte_at;
  logic          in_store;
  logic [SW-1:0] ext_sum;
  logic [LW-1:0] ptr_nxt;
  logic [7:0]    bit_mask;
  logic          hit;
  logic [2:0]    hit_idx;
  logic [LW+2:0] found_idx;

  function automatic out_item_t mk_res(stat_e st, logic rb, logic [BitIdxW-1:0] fi,
                                       logic [LW-1:0] len);
    out_item_t r;
    r.status          = st;
    r.read_bit        = rb;
    r.found_bit_index = fi;
    r.length_now      = LenOutW'(len);
    return r;
  endfunction

  bsff_bit_find u_bit_find (
    .byte_i (mem_rdata_i),
    .want_i (item_q.bit_value),
    .hit_o  (hit),
    .idx_o  (hit_idx)
  );

  assign byte_at   = item_i.bit_index[BitIdxW-1:3];
  assign in_store  = SW'(byte_at) < StoreSize;
  assign ext_sum   = SW'(len_q) + SW'(item_i.fill_count);
  assign ptr_nxt   = ptr_q + 1'b1;
  assign bit_mask  = 8'd1 << item_q.bit_index[2:0];
  assign found_idx = {ptr_q, hit_idx};

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    ptr_d     = ptr_q;
    end_d     = end_q;
    len_d     = len_q;
    done_d    = 1'b0;
    res_d     = res_q;
    mem_req_o = '0;

    case (state_q)
      S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = MemAddrW'(ptr_q);
        mem_req_o.wdata = 8'd0;
        ptr_d           = ptr_nxt;
        if (ptr_q == LastByte) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start_i) begin
          item_d = item_i;
          case (cmd_e'(item_i.command))
            CMD_READ, CMD_ASSIGN, CMD_TOGGLE: begin
              if (in_store) begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = MemAddrW'(byte_at);
                state_d         = S_RMW;
              end else begin
                res_d  = mk_res(ST_OK, 1'b0, '0, len_q);
                done_d = 1'b1;
              end
            end
            CMD_FIND: begin
              if (SW'(item_i.start_byte) < SW'(len_q)) begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = MemAddrW'(item_i.start_byte);
                ptr_d           = LW'(item_i.start_byte);
                state_d         = S_SCAN;
              end else begin
                res_d  = mk_res(ST_NOT_FOUND, 1'b0, '0, len_q);
                done_d = 1'b1;
              end
            end
            CMD_EXTEND: begin
              if (ext_sum > StoreSize) begin
                res_d  = mk_res(ST_OVERFLOW, 1'b0, '0, len_q);
                done_d = 1'b1;
              end else if (item_i.fill_count == '0) begin
                res_d  = mk_res(ST_OK, 1'b0, '0, len_q);
                done_d = 1'b1;
              end else begin
                ptr_d   = len_q;
                end_d   = LW'(ext_sum);
                state_d = S_FILL;
              end
            end
            default: begin
              res_d  = mk_res(ST_OK, 1'b0, '0, len_q);
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_RMW: begin
        mem_req_o.waddr = MemAddrW'(item_q.bit_index[BitIdxW-1:3]);
        case (cmd_e'(item_q.command))
          CMD_READ: begin
            res_d = mk_res(ST_OK, |(mem_rdata_i & bit_mask), '0, len_q);
          end
          CMD_ASSIGN: begin
            mem_req_o.we    = 1'b1;
            mem_req_o.wdata = item_q.bit_value ? (mem_rdata_i | bit_mask)
                                               : (mem_rdata_i & ~bit_mask);
            res_d           = mk_res(ST_OK, 1'b0, '0, len_q);
          end
          CMD_TOGGLE: begin
            mem_req_o.we    = 1'b1;
            mem_req_o.wdata = mem_rdata_i ^ bit_mask;
            res_d           = mk_res(ST_OK, 1'b0, '0, len_q);
          end
          default: begin
            res_d = mk_res(ST_OK, 1'b0, '0, len_q);
          end
        endcase
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      S_SCAN: begin
        // data for ptr_q arrives now; fetch the next byte speculatively
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = MemAddrW'(ptr_nxt);
        if (hit) begin
          res_d   = mk_res(ST_OK, 1'b0, BitIdxW'(found_idx), len_q);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (ptr_nxt == len_q) begin
          res_d   = mk_res(ST_NOT_FOUND, 1'b0, '0, len_q);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_nxt;
        end
      end

      S_FILL: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = MemAddrW'(ptr_q);
        mem_req_o.wdata = item_q.fill_byte;
        ptr_d           = ptr_nxt;
        if (ptr_nxt == end_q) begin
          len_d   = end_q;
          res_d   = mk_res(ST_OK, 1'b0, '0, end_q);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ptr_q   <= '0;
      len_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      len_q   <= len_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    end_q  <= end_d;
    res_q  <= res_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== rtl/core/bitmap_store_find_first.sv =====
// Channel   Ports                         Transfer
// --------  ----------------------------  -------------------------------------
// command   start, busy, item_i           accepted when start is high, busy low
// result    done_o, result_o              one cycle per result, done_o marks it
//
// Bit read/assign/toggle: in the store the byte is read, then modified and
// written back; past the store the answer needs no memory access. Find: one
// byte read per cycle from the memory, from start_byte up to the current
// length. Extend: one byte written per cycle, fill_count bytes from the current
// length; overflow or zero count is answered from idle. One transaction is in
// flight at a time; busy is high until its result is registered. After reset a
// clearing pass zeroes the store (busy high); the receiver cannot stall done_o.
module bitmap_store_find_first #(
  parameter int unsigned STORE_BYTES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  bsff_pkg::in_item_t   item_i,
  output logic                 done_o,
  output bsff_pkg::out_item_t  result_o
);
  import bsff_pkg::*;

  localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  mem_req_t   mem_req;
  logic [7:0] store_q [STORE_BYTES];
  logic [7:0] rdata_q;

  // sequencer: clearing pass, read-modify-write, scan and fill walks
  bsff_seq #(
    .STORE_BYTES (STORE_BYTES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (rdata_q)
  );

  // byte store: one write and one registered read per cycle.
  // Only one transaction runs at a time, so a write never races a read
  // of the same byte that it depends on.
  always_ff @(posedge clk_i) begin
    if (mem_req.we) begin
      store_q[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
    end
    if (mem_req.re) begin
      rdata_q <= store_q[mem_req.raddr[AW-1:0]];
    end
  end

endmodule

// ===== rtl/core/bsff_chk.sv =====
module bsff_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input bsff_pkg::in_item_t  item_i,
  input logic                done_o,
  input bsff_pkg::out_item_t result_o
);
  import bsff_pkg::*;

  // an accepted transaction either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted transaction neither busy nor answered");

  // a result shows only once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while busy");

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_NOT_FOUND) |-> (result_o.found_bit_index == '0))
    else $error("not-found result carries an index");

  a_readbit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.read_bit) |-> (result_o.status == ST_OK))
    else $error("read bit set on failing status");

endmodule

bind bitmap_store_find_first bsff_chk u_bsff_chk (.*);
